// ===== rtl/core/dmc_pkg.sv =====
// Shared types, constants and helper functions of the depth-first maze carver.
// Used by dmc_ctrl, dmc_dp and dfs_maze_carver; depends on nothing else.
package dmc_pkg;

    localparam int MAX_ROWS = 16;
    localparam int MAX_COLS = 16;
    localparam int CELLS    = MAX_ROWS * MAX_COLS;

    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int DROW_W   = $clog2(MAX_ROWS + 1);
    localparam int DCOL_W   = $clog2(MAX_COLS + 1);
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int CNT_W    = $clog2(CELLS + 1);

    localparam int CFG_W    = 5;
    localparam int RND_W    = 16;
    localparam int OCRD_W   = 4;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [CFG_W-1:0] GRID_RESET = CFG_W'(12);

    // Register index, taken from paddr[2].
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Command field of an input item.
    localparam logic CMD_BEGIN = 1'b0;

    // Wall side of a reported wall.
    localparam logic SIDE_RIGHT  = 1'b0;
    localparam logic SIDE_BOTTOM = 1'b1;

    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [DROW_W-1:0] t_drow;
    typedef logic [DCOL_W-1:0] t_dcol;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_CARVE = 2'd1,
        ACT_BACK  = 2'd2,
        ACT_IDLE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_LEFT  = 2'd3
    } t_dir;

    typedef struct packed {
        t_row row;
        t_col col;
    } t_cell;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;    // clear one visited entry of the sweep
        logic start;       // begin a new maze: push the start cell
        logic take_step;   // latch the random value of a step
        logic set_idle;    // step on an empty stack
        logic check;       // mark the top visited, read up and right
        logic read2;       // read down and left, keep up and right
        logic push;        // carve to the chosen neighbor
        logic pop;         // drop the top, read the new top
        logic pop_rd;      // capture the new top
        logic load_out;    // load the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic stack_empty;
        logic out_of_grid;
        logic no_cand;
    } t_dp_sts;

    function automatic t_addr cell_addr(input t_row r, input t_col c);
        return t_addr'(r) * t_addr'(MAX_COLS) + t_addr'(c);
    endfunction

    function automatic t_drow clamp_rows(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return t_drow'(1);
        end
        if (int'(v) > MAX_ROWS) begin
            return t_drow'(MAX_ROWS);
        end
        return t_drow'(v);
    endfunction

    function automatic t_dcol clamp_cols(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return t_dcol'(1);
        end
        if (int'(v) > MAX_COLS) begin
            return t_dcol'(MAX_COLS);
        end
        return t_dcol'(v);
    endfunction

    // Remainder by three: base-4 digits are summed twice (4 is 1 modulo 3),
    // then at most one subtraction finishes it.
    function automatic logic [1:0] mod3_16(input logic [RND_W-1:0] v);
        logic [4:0] s;
        logic [2:0] t;
        s = '0;
        for (int i = 0; i < RND_W / 2; i++) begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

endpackage

// ===== rtl/core/dmc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stands alone; used for the visited map and the cell stack.
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/dmc_ctrl.sv =====
// Sequencing state machine of the maze carver: handshakes and datapath commands.
// Depends on dmc_pkg.
module dmc_ctrl import dmc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  logic    i_cmd,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_dp_cmd,
    input  t_dp_sts i_dp_sts
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_READ2,
        S_EVAL,
        S_POPRD,
        S_DONE
    } t_state;

    t_state  r_state, n_state;
    logic    r_pend, n_pend;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        cmd     = '0;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_dp_sts.clr_last) begin
                    n_state = r_pend ? S_DONE : S_IDLE;
                    n_pend  = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_cmd == CMD_BEGIN) begin
                        cmd.start = 1'b1;
                        n_pend    = 1'b1;
                        n_state   = S_CLEAR;
                    end else if (i_dp_sts.stack_empty) begin
                        cmd.set_idle = 1'b1;
                        n_state      = S_DONE;
                    end else begin
                        cmd.take_step = 1'b1;
                        n_state       = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_dp_sts.out_of_grid) begin
                    cmd.pop = 1'b1;
                    n_state = S_POPRD;
                end else begin
                    cmd.check = 1'b1;
                    n_state   = S_READ2;
                end
            end
            S_READ2: begin
                cmd.read2 = 1'b1;
                n_state   = S_EVAL;
            end
            S_EVAL: begin
                if (i_dp_sts.no_cand) begin
                    cmd.pop = 1'b1;
                    n_state = S_POPRD;
                end else begin
                    cmd.push = 1'b1;
                    n_state  = S_DONE;
                end
            end
            S_POPRD: begin
                cmd.pop_rd = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_dp_cmd    = cmd;

endmodule

// ===== rtl/core/dmc_dp.sv =====
// Datapath of the maze carver: stack top, stack and visited memories,
// neighbor selection and the output register. Depends on dmc_pkg and dmc_ram.
module dmc_dp import dmc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_dp_cmd,
    output t_dp_sts           o_dp_sts,
    input  t_drow             i_rows,
    input  t_dcol             i_cols,
    input  logic [RND_W-1:0]  i_rnd,
    output logic [1:0]        o_action,
    output logic [OCRD_W-1:0] o_wall_row,
    output logic [OCRD_W-1:0] o_wall_col,
    output logic              o_wall_side,
    output logic [OCRD_W-1:0] o_top_row,
    output logic [OCRD_W-1:0] o_top_col,
    output logic              o_stack_empty
);

    // Control state.
    t_cnt  r_count;
    t_addr r_sweep;

    // Payload state.
    t_row       r_top_row;
    t_col       r_top_col;
    logic [1:0] r_rnd_lo;
    logic [1:0] r_rnd_m3;
    logic       r_vis_up;
    logic       r_vis_right;
    t_action    r_action;
    t_row       r_wall_row;
    t_col       r_wall_col;
    logic       r_wall_side;

    t_action           r_o_action;
    logic [OCRD_W-1:0] r_o_wall_row;
    logic [OCRD_W-1:0] r_o_wall_col;
    logic              r_o_wall_side;
    logic [OCRD_W-1:0] r_o_top_row;
    logic [OCRD_W-1:0] r_o_top_col;
    logic              r_o_empty;

    t_row  row_up, row_dn;
    t_col  col_rt, col_lf;
    t_addr a_self, a_up, a_rt, a_dn, a_lf;
    logic  up_ok, rt_ok, dn_ok, lf_ok;
    logic  vis_we, vis_wdata;
    t_addr vis_waddr, vis_raddr_a, vis_raddr_b;
    logic  vis_rd_a, vis_rd_b;
    logic  vis_rd_a2, vis_rd_b2;
    logic [3:0] cand;
    logic [2:0] n_cand;
    logic [1:0] pick;
    logic [1:0] seen;
    logic       found;
    t_dir  dir;
    t_cell nbr;
    t_row  wall_row;
    t_col  wall_col;
    logic  wall_side;
    logic  stk_full;
    logic  stk_we;
    t_addr stk_waddr, stk_raddr;
    t_cell stk_wdata, stk_rdata;
    t_cell start_cell;

    assign row_up = r_top_row - 1'b1;
    assign row_dn = r_top_row + 1'b1;
    assign col_rt = r_top_col + 1'b1;
    assign col_lf = r_top_col - 1'b1;

    assign a_self = cell_addr(r_top_row, r_top_col);
    assign a_up   = cell_addr(row_up, r_top_col);
    assign a_dn   = cell_addr(row_dn, r_top_col);
    assign a_rt   = cell_addr(r_top_row, col_rt);
    assign a_lf   = cell_addr(r_top_row, col_lf);

    assign up_ok = (r_top_row != '0);
    assign lf_ok = (r_top_col != '0);
    assign dn_ok = ((t_drow'(r_top_row) + t_drow'(1)) < i_rows);
    assign rt_ok = ((t_dcol'(r_top_col) + t_dcol'(1)) < i_cols);

    // Visited map: two copies written together, so that two neighbors are
    // read in each cycle.
    assign vis_we      = i_dp_cmd.clr_step | i_dp_cmd.check;
    assign vis_waddr   = i_dp_cmd.clr_step ? r_sweep : a_self;
    assign vis_wdata   = i_dp_cmd.check;
    assign vis_raddr_a = i_dp_cmd.check ? a_up : a_dn;
    assign vis_raddr_b = i_dp_cmd.check ? a_rt : a_lf;

    dmc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_vis_a (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (vis_wdata),
        .i_raddr (vis_raddr_a),
        .o_rdata (vis_rd_a)
    );

    dmc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_vis_b (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (vis_wdata),
        .i_raddr (vis_raddr_b),
        .o_rdata (vis_rd_b)
    );

    assign vis_rd_a2 = vis_rd_a;
    assign vis_rd_b2 = vis_rd_b;

    // Candidates in the order up, right, down, left.
    assign cand[0] = up_ok & ~r_vis_up;
    assign cand[1] = rt_ok & ~r_vis_right;
    assign cand[2] = dn_ok & ~vis_rd_a2;
    assign cand[3] = lf_ok & ~vis_rd_b2;
    assign n_cand  = 3'($countones(cand));

    always_comb begin
        case (n_cand)
            3'd2:    pick = {1'b0, r_rnd_lo[0]};
            3'd3:    pick = r_rnd_m3;
            3'd4:    pick = r_rnd_lo;
            default: pick = 2'd0;
        endcase

        dir   = DIR_UP;
        seen  = 2'd0;
        found = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (cand[i] && !found) begin
                if (seen == pick) begin
                    dir   = t_dir'(i);
                    found = 1'b1;
                end
                seen = seen + 2'd1;
            end
        end

        case (dir)
            DIR_UP: begin
                nbr       = '{row: row_up, col: r_top_col};
                wall_row  = row_up;
                wall_col  = r_top_col;
                wall_side = SIDE_BOTTOM;
            end
            DIR_RIGHT: begin
                nbr       = '{row: r_top_row, col: col_rt};
                wall_row  = r_top_row;
                wall_col  = r_top_col;
                wall_side = SIDE_RIGHT;
            end
            DIR_DOWN: begin
                nbr       = '{row: row_dn, col: r_top_col};
                wall_row  = r_top_row;
                wall_col  = r_top_col;
                wall_side = SIDE_BOTTOM;
            end
            default: begin
                nbr       = '{row: r_top_row, col: col_lf};
                wall_row  = r_top_row;
                wall_col  = col_lf;
                wall_side = SIDE_RIGHT;
            end
        endcase
    end

    // Cell stack.
    assign start_cell = '{row: t_row'(i_rows - t_drow'(1)), col: t_col'(i_cols - t_dcol'(1))};
    assign stk_full   = (r_count == t_cnt'(CELLS));
    assign stk_we     = i_dp_cmd.start | (i_dp_cmd.push & ~stk_full);
    assign stk_waddr  = i_dp_cmd.start ? t_addr'(0) : r_count[ADDR_W-1:0];
    assign stk_wdata  = i_dp_cmd.start ? start_cell : nbr;
    assign stk_raddr  = t_addr'(r_count - t_cnt'(2));

    dmc_ram #(.WIDTH($bits(t_cell)), .DEPTH(CELLS)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sweep <= '0;
        end else begin
            if (i_dp_cmd.clr_step) begin
                r_sweep <= (r_sweep == t_addr'(CELLS - 1)) ? '0 : r_sweep + 1'b1;
            end
            if (i_dp_cmd.start) begin
                r_count <= t_cnt'(1);
            end else if (i_dp_cmd.push && !stk_full) begin
                r_count <= r_count + 1'b1;
            end else if (i_dp_cmd.pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.start) begin
            r_top_row <= start_cell.row;
            r_top_col <= start_cell.col;
        end else if (i_dp_cmd.push && !stk_full) begin
            r_top_row <= nbr.row;
            r_top_col <= nbr.col;
        end else if (i_dp_cmd.pop_rd && r_count != '0) begin
            r_top_row <= stk_rdata.row;
            r_top_col <= stk_rdata.col;
        end

        if (i_dp_cmd.take_step) begin
            r_rnd_lo <= i_rnd[1:0];
            r_rnd_m3 <= mod3_16(i_rnd);
        end
        if (i_dp_cmd.read2) begin
            r_vis_up    <= vis_rd_a;
            r_vis_right <= vis_rd_b;
        end

        if (i_dp_cmd.push) begin
            r_action    <= ACT_CARVE;
            r_wall_row  <= wall_row;
            r_wall_col  <= wall_col;
            r_wall_side <= wall_side;
        end else if (i_dp_cmd.start || i_dp_cmd.set_idle || i_dp_cmd.pop) begin
            if (i_dp_cmd.start) begin
                r_action <= ACT_START;
            end else if (i_dp_cmd.set_idle) begin
                r_action <= ACT_IDLE;
            end else begin
                r_action <= ACT_BACK;
            end
            r_wall_row  <= '0;
            r_wall_col  <= '0;
            r_wall_side <= 1'b0;
        end

        if (i_dp_cmd.load_out) begin
            r_o_action    <= r_action;
            r_o_wall_row  <= OCRD_W'(r_wall_row);
            r_o_wall_col  <= OCRD_W'(r_wall_col);
            r_o_wall_side <= r_wall_side;
            r_o_top_row   <= (r_count == '0) ? '0 : OCRD_W'(r_top_row);
            r_o_top_col   <= (r_count == '0) ? '0 : OCRD_W'(r_top_col);
            r_o_empty     <= (r_count == '0);
        end
    end

    assign o_dp_sts.clr_last    = (r_sweep == t_addr'(CELLS - 1));
    assign o_dp_sts.stack_empty = (r_count == '0);
    assign o_dp_sts.out_of_grid = (t_drow'(r_top_row) >= i_rows) ||
                                  (t_dcol'(r_top_col) >= i_cols);
    assign o_dp_sts.no_cand     = (cand == 4'b0000);

    assign o_action      = r_o_action;
    assign o_wall_row    = r_o_wall_row;
    assign o_wall_col    = r_o_wall_col;
    assign o_wall_side   = r_o_wall_side;
    assign o_top_row     = r_o_top_row;
    assign o_top_col     = r_o_top_col;
    assign o_stack_empty = r_o_empty;

endmodule

// ===== rtl/core/dfs_maze_carver.sv =====
// Top level of the depth-first maze carver: configuration registers and the
// controller and datapath. Depends on dmc_pkg, dmc_ctrl, dmc_dp and dmc_ram.
//
//  channel  direction  handshake                    payload
//  -------  ---------  ---------------------------  --------------------------------
//  in       to block   i_in_valid / o_in_stall      i_cmd, i_rnd
//  out      from block o_out_valid / i_out_stall    o_action, o_wall_row, o_wall_col,
//                                                   o_wall_side, o_top_row, o_top_col,
//                                                   o_stack_empty
//  cfg      APB        psel, penable, pready        paddr, pwdata, pwrite, prdata
//
// One item is worked on at a time. A carving step passes the states CHECK, READ2,
// EVAL and DONE; a backtracking step pops in EVAL, or in CHECK if the top lies
// outside the grid, and captures the new top in POPRD before DONE; a step on an
// empty stack goes straight to DONE. The visited map's two copies give two
// neighbor reads per cycle, so the four neighbors are read in CHECK and READ2.
// A begin command clears the visited map one entry per cycle. After reset the
// same clearing pass runs, during which the input is stalled; configuration
// writes are taken at any time. The result sits in an output register, so
// a stalled output blocks only the following result's delivery, not the next input.
module dfs_maze_carver import dmc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_cmd,
    input  logic [RND_W-1:0]   i_rnd,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_action,
    output logic [OCRD_W-1:0]  o_wall_row,
    output logic [OCRD_W-1:0]  o_wall_col,
    output logic               o_wall_side,
    output logic [OCRD_W-1:0]  o_top_row,
    output logic [OCRD_W-1:0]  o_top_col,
    output logic               o_stack_empty,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [CFG_W-1:0] r_grid_rows;
    logic [CFG_W-1:0] r_grid_cols;
    logic             cfg_write;
    t_drow            rows;
    t_dcol            cols;
    t_dp_cmd          dp_cmd;
    t_dp_sts          dp_sts;

    // The registers sit at byte addresses 0 and 4; the low address bits are
    // ignored, so paddr[2] selects the register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= GRID_RESET;
            r_grid_cols <= GRID_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_ROWS: r_grid_rows <= pwdata[CFG_W-1:0];
                REG_COLS: r_grid_cols <= pwdata[CFG_W-1:0];
                default:  r_grid_rows <= r_grid_rows;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ROWS: prdata = PDATA_W'(r_grid_rows);
            REG_COLS: prdata = PDATA_W'(r_grid_cols);
            default:  prdata = '0;
        endcase
    end

    // A size of zero acts as one, and a size above the grid the block was
    // built for saturates to it.
    assign rows = clamp_rows(r_grid_rows);
    assign cols = clamp_cols(r_grid_cols);

    dmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dp_cmd    (dp_cmd),
        .i_dp_sts    (dp_sts)
    );

    dmc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp_cmd      (dp_cmd),
        .o_dp_sts      (dp_sts),
        .i_rows        (rows),
        .i_cols        (cols),
        .i_rnd         (i_rnd),
        .o_action      (o_action),
        .o_wall_row    (o_wall_row),
        .o_wall_col    (o_wall_col),
        .o_wall_side   (o_wall_side),
        .o_top_row     (o_top_row),
        .o_top_col     (o_top_col),
        .o_stack_empty (o_stack_empty)
    );

    // The clearing pass after reset keeps the input stalled.
    a_stall_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> o_in_stall)
        else $error("input not stalled during the clearing pass after reset");

    // A step on an empty stack leaves it empty.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action == ACT_IDLE) |-> o_stack_empty)
        else $error("idle result with a non-empty stack");

    // Only a carve reports a wall.
    a_wall_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action != ACT_CARVE) |->
        (o_wall_row == '0 && o_wall_col == '0 && !o_wall_side))
        else $error("wall reported without a carve");

    // A carve or a start leaves at least one cell on the stack.
    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_action == ACT_CARVE || o_action == ACT_START)) |->
        !o_stack_empty)
        else $error("empty stack after a push");

endmodule

// ===== test/dfs_maze_carver_tb.sv =====
// Self-checking testbench of dfs_maze_carver: begin and step commands over a
// range of grid sizes, each result predicted or typed in the bench and checked
// field by field. Depends on dmc_pkg and the dfs_maze_carver RTL; reads no files.
module dfs_maze_carver_tb import dmc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_ITEMS    = 1850;
    localparam int QUIET_ITEMS   = 200;   // tail of the run with no idling on either side
    localparam int WATCHDOG_MAX  = 2000;  // begin clears 256 entries, plus stalls and gaps
    localparam int SETTLE_CYCLES = 20;
    localparam int SCRIPT_LEN    = 32;

    localparam logic CMD_STEP = ~CMD_BEGIN;

    // One result of the block, at the widths of its output ports.
    typedef struct packed {
        t_action             action;
        logic [OCRD_W-1:0]   wall_row;
        logic [OCRD_W-1:0]   wall_col;
        logic                wall_side;
        logic [OCRD_W-1:0]   top_row;
        logic [OCRD_W-1:0]   top_col;
        logic                stack_empty;
    } t_carve_result;

    typedef enum logic [1:0] {
        ROW_PREDICT,    // command, result from the predictor
        ROW_TYPED,      // command, result written out below
        ROW_GRID        // wait for idle, then write both grid registers
    } t_script_kind;

    typedef struct {
        t_script_kind      kind;
        logic              cmd;
        logic [RND_W-1:0]  rnd;
        logic [CFG_W-1:0]  rows;
        logic [CFG_W-1:0]  cols;
        t_carve_result     res;
    } t_script_row;

    localparam t_carve_result IDLE_RES =
        '{ACT_IDLE, 4'd0, 4'd0, SIDE_RIGHT, 4'd0, 4'd0, 1'b1};
    localparam t_carve_result EMPTIED_RES =
        '{ACT_BACK, 4'd0, 4'd0, SIDE_RIGHT, 4'd0, 4'd0, 1'b1};

    // Directed opening. Begins, steps on an empty stack and the one-cell grids have
    // results that are obvious, so they are typed in. Everything else goes through
    // the predictor. It covers zero and oversized grid values, a begin in the middle of a
    // maze, and a grid shrunk under a live stack, which must unwind by backtracking.
    t_script_row script [SCRIPT_LEN] = '{
        '{ROW_TYPED,   CMD_STEP,  16'h0000, '0, '0, IDLE_RES},
        '{ROW_TYPED,   CMD_BEGIN, 16'hFFFF, '0, '0,
          '{ACT_START, 4'd0, 4'd0, SIDE_RIGHT, 4'd11, 4'd11, 1'b0}},
        '{ROW_PREDICT, CMD_STEP,  16'h0000, '0, '0, '0},
        '{ROW_PREDICT, CMD_STEP,  16'hFFFF, '0, '0, '0},
        '{ROW_PREDICT, CMD_STEP,  16'h5555, '0, '0, '0},
        '{ROW_PREDICT, CMD_STEP,  16'hAAAA, '0, '0, '0},
        '{ROW_TYPED,   CMD_BEGIN, 16'h0000, '0, '0,
          '{ACT_START, 4'd0, 4'd0, SIDE_RIGHT, 4'd11, 4'd11, 1'b0}},
        '{ROW_PREDICT, CMD_STEP,  16'h0001, '0, '0, '0},
        '{ROW_GRID,    CMD_STEP,  16'h0000, 5'd1, 5'd1, '0},
        '{ROW_TYPED,   CMD_BEGIN, 16'h0000, '0, '0,
          '{ACT_START, 4'd0, 4'd0, SIDE_RIGHT, 4'd0, 4'd0, 1'b0}},
        '{ROW_TYPED,   CMD_STEP,  16'hFFFF, '0, '0, EMPTIED_RES},
        '{ROW_TYPED,   CMD_STEP,  16'h0000, '0, '0, IDLE_RES},
        '{ROW_GRID,    CMD_STEP,  16'h0000, 5'd0, 5'd0, '0},
        '{ROW_TYPED,   CMD_BEGIN, 16'hFFFF, '0, '0,
          '{ACT_START, 4'd0, 4'd0, SIDE_RIGHT, 4'd0, 4'd0, 1'b0}},
        '{ROW_TYPED,   CMD_STEP,  16'h0000, '0, '0, EMPTIED_RES},
        '{ROW_GRID,    CMD_STEP,  16'h0000, 5'd31, 5'd31, '0},
        '{ROW_TYPED,   CMD_BEGIN, 16'h0000, '0, '0,
          '{ACT_START, 4'd0, 4'd0, SIDE_RIGHT, 4'd15, 4'd15, 1'b0}},
        '{ROW_PREDICT, CMD_STEP,  16'hFFFF, '0, '0, '0},
        '{ROW_PREDICT, CMD_STEP,  16'h0000, '0, '0, '0},
        '{ROW_PREDICT, CMD_STEP,  16'h8000, '0, '0, '0},
        '{ROW_PREDICT, CMD_STEP,  16'h7FFF, '0, '0, '0},
        '{ROW_GRID,    CMD_STEP,  16'h0000, 5'd2, 5'd2, '0},
        '{ROW_PREDICT, CMD_STEP,  16'h1234, '0, '0, '0},
        '{ROW_PREDICT, CMD_STEP,  16'h4321, '0, '0, '0},
        '{ROW_GRID,    CMD_STEP,  16'h0000, 5'd16, 5'd1, '0},
        '{ROW_TYPED,   CMD_BEGIN, 16'h0000, '0, '0,
          '{ACT_START, 4'd0, 4'd0, SIDE_RIGHT, 4'd15, 4'd0, 1'b0}},
        '{ROW_PREDICT, CMD_STEP,  16'h0003, '0, '0, '0},
        '{ROW_PREDICT, CMD_STEP,  16'h0002, '0, '0, '0},
        '{ROW_GRID,    CMD_STEP,  16'h0000, 5'd1, 5'd16, '0},
        '{ROW_TYPED,   CMD_BEGIN, 16'hFFFF, '0, '0,
          '{ACT_START, 4'd0, 4'd0, SIDE_RIGHT, 4'd0, 4'd15, 1'b0}},
        '{ROW_PREDICT, CMD_STEP,  16'hFFFE, '0, '0, '0},
        '{ROW_PREDICT, CMD_STEP,  16'h0000, '0, '0, '0}
    };

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    logic               i_cmd       = CMD_STEP;
    logic [RND_W-1:0]   i_rnd       = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_action;
    logic [OCRD_W-1:0]  o_wall_row;
    logic [OCRD_W-1:0]  o_wall_col;
    logic               o_wall_side;
    logic [OCRD_W-1:0]  o_top_row;
    logic [OCRD_W-1:0]  o_top_col;
    logic               o_stack_empty;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    dfs_maze_carver dut (.*);

    always #5 i_clk = ~i_clk;

    // The bench's own copy of the carver: grid registers, visited map and the
    // stack of cells on the current path.
    logic [CFG_W-1:0] grid_rows_q = GRID_RESET;
    logic [CFG_W-1:0] grid_cols_q = GRID_RESET;
    bit               visited_q [CELLS];
    t_row             trail_row [CELLS];
    t_col             trail_col [CELLS];
    int               trail_depth = 0;

    t_carve_result    expected_moves [$];
    int               mismatches   = 0;
    int               idle_cycles  = 0;
    int               hold_left    = 0;
    int               gap_pct      = 20;
    bit               quiet_tail   = 1'b0;

    // A zero register acts as one row or column, anything past the array saturates.
    function automatic int grid_extent(input logic [CFG_W-1:0] v, input int limit);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > limit) begin
            return limit;
        end
        return int'(v);
    endfunction

    function automatic void push_trail(input int r, input int c);
        if (trail_depth < CELLS) begin
            trail_row[trail_depth] = t_row'(r);
            trail_col[trail_depth] = t_col'(c);
            trail_depth++;
        end
    endfunction

    // Works out the result of one command and moves the bench's state along.
    function automatic t_carve_result carve_predict(input logic cmd,
                                                    input logic [RND_W-1:0] rnd);
        t_carve_result res;
        t_dir          cand [4];
        int            rows;
        int            cols;
        int            r;
        int            c;
        int            n;
        res  = '0;
        rows = grid_extent(grid_rows_q, MAX_ROWS);
        cols = grid_extent(grid_cols_q, MAX_COLS);
        if (cmd == CMD_BEGIN) begin
            foreach (visited_q[i]) visited_q[i] = 1'b0;
            trail_depth = 0;
            push_trail(rows - 1, cols - 1);
            res.action = ACT_START;
        end else if (trail_depth == 0) begin
            res.action = ACT_IDLE;
        end else begin
            r = int'(trail_row[trail_depth-1]);
            c = int'(trail_col[trail_depth-1]);
            if (r >= rows || c >= cols) begin
                // The grid shrank under this cell: drop it without marking it.
                trail_depth--;
                res.action = ACT_BACK;
            end else begin
                visited_q[r*MAX_COLS + c] = 1'b1;
                n = 0;
                if (r != 0 && !visited_q[(r-1)*MAX_COLS + c]) begin
                    cand[n] = DIR_UP;
                    n++;
                end
                if (c + 1 < cols && !visited_q[r*MAX_COLS + c + 1]) begin
                    cand[n] = DIR_RIGHT;
                    n++;
                end
                if (r + 1 < rows && !visited_q[(r+1)*MAX_COLS + c]) begin
                    cand[n] = DIR_DOWN;
                    n++;
                end
                if (c != 0 && !visited_q[r*MAX_COLS + c - 1]) begin
                    cand[n] = DIR_LEFT;
                    n++;
                end
                if (n == 0) begin
                    trail_depth--;
                    res.action = ACT_BACK;
                end else begin
                    // Walls are always named by the upper or left cell of the pair.
                    res.action = ACT_CARVE;
                    case (cand[int'(rnd) % n])
                        DIR_UP: begin
                            res.wall_row  = OCRD_W'(r - 1);
                            res.wall_col  = OCRD_W'(c);
                            res.wall_side = SIDE_BOTTOM;
                            push_trail(r - 1, c);
                        end
                        DIR_RIGHT: begin
                            res.wall_row  = OCRD_W'(r);
                            res.wall_col  = OCRD_W'(c);
                            res.wall_side = SIDE_RIGHT;
                            push_trail(r, c + 1);
                        end
                        DIR_DOWN: begin
                            res.wall_row  = OCRD_W'(r);
                            res.wall_col  = OCRD_W'(c);
                            res.wall_side = SIDE_BOTTOM;
                            push_trail(r + 1, c);
                        end
                        default: begin
                            res.wall_row  = OCRD_W'(r);
                            res.wall_col  = OCRD_W'(c - 1);
                            res.wall_side = SIDE_RIGHT;
                            push_trail(r, c - 1);
                        end
                    endcase
                end
            end
        end
        if (trail_depth > 0) begin
            res.top_row = OCRD_W'(trail_row[trail_depth-1]);
            res.top_col = OCRD_W'(trail_col[trail_depth-1]);
        end
        res.stack_empty = (trail_depth == 0);
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim(input int limit);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            return CFG_W'($urandom_range(1, 8));
        end else if (sel < 8) begin
            return CFG_W'($urandom_range(9, limit));
        end
        return CFG_W'($urandom_range(0, 31));
    endfunction

    function automatic logic [RND_W-1:0] pick_rnd();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return RND_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Output side: every result transfer is checked against the oldest expectation.
    // The same block watches for a hang: too many cycles without any transfer.
    always @(posedge i_clk) begin
        t_carve_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_moves.size() == 0) begin
                $error("result transfer with no command outstanding");
                mismatches++;
            end else begin
                want = expected_moves.pop_front();
                check_field("action",      want.action,      o_action);
                check_field("wall_row",    want.wall_row,    o_wall_row);
                check_field("wall_col",    want.wall_col,    o_wall_col);
                check_field("wall_side",   want.wall_side,   o_wall_side);
                check_field("top_row",     want.top_row,     o_top_row);
                check_field("top_col",     want.top_col,     o_top_col);
                check_field("stack_empty", want.stack_empty, o_stack_empty);
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("dfs_maze_carver_tb: FAIL");
                $finish;
            end
        end
    end

    // Output backpressure: stall bursts between free runs, some of the runs long,
    // and no stall at all once the quiet tail starts.
    always @(posedge i_clk) begin
        if (quiet_tail) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
        end else if (!i_out_stall && $urandom_range(0, 1) == 1) begin
            i_out_stall <= 1'b1;
            hold_left = $urandom_range(0, 17);
        end else begin
            i_out_stall <= 1'b0;
            hold_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                    : $urandom_range(0, 10);
        end
    end

    // One input transfer, after an optional gap. The expectation is queued at the
    // edge that takes the transfer; a typed result replaces the predicted one.
    task automatic send_item(input logic cmd, input logic [RND_W-1:0] rnd,
                             input bit typed, input t_carve_result typed_res);
        t_carve_result want;
        if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_rnd      <= rnd;
        do @(posedge i_clk); while (o_in_stall);
        want = carve_predict(cmd, rnd);
        expected_moves = {expected_moves, (typed ? typed_res : want)};
    endtask

    // Hold the input back until every expected result has come out.
    task automatic drain();
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
        end
        while (expected_moves.size() != 0) @(posedge i_clk);
    endtask

    // Setup cycle, access cycle, then the bus goes idle.
    task automatic apb_transfer(input logic is_write, input logic index,
                                input logic [CFG_W-1:0] value,
                                output logic [PDATA_W-1:0] rdata);
        logic [PDATA_W-1:0] word;
        word = $urandom();
        word[CFG_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {index, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata    = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_grid();
        logic [PDATA_W-1:0] rdata;
        apb_transfer(1'b0, REG_ROWS, '0, rdata);
        check_field("grid_rows", grid_rows_q, rdata[CFG_W-1:0]);
        apb_transfer(1'b0, REG_COLS, '0, rdata);
        check_field("grid_cols", grid_cols_q, rdata[CFG_W-1:0]);
    endtask

    // Only called with the block idle. The bench's copy changes with the write.
    task automatic write_grid(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        logic [PDATA_W-1:0] rdata;
        apb_transfer(1'b1, REG_ROWS, rows, rdata);
        grid_rows_q = rows;
        apb_transfer(1'b1, REG_COLS, cols, rdata);
        grid_cols_q = cols;
        check_grid();
    endtask

    initial begin
        int rand_items;
        int phase;
        int roll;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The registers come up at their reset size while the visited map clears.
        check_grid();

        foreach (script[i]) begin
            if (script[i].kind == ROW_GRID) begin
                drain();
                write_grid(script[i].rows, script[i].cols);
            end else begin
                send_item(script[i].cmd, script[i].rnd, script[i].kind == ROW_TYPED,
                          script[i].res);
            end
        end

        // Random part: mostly whole mazes carved to the end on a fresh grid size,
        // with stray begins and steps mixed in, the odd resize under a live
        // stack, and a few idle steps once a maze is finished.
        rand_items = 0;
        phase      = 0;
        while (rand_items < RAND_ITEMS) begin
            drain();
            if (phase % 8 == 3) begin
                write_grid(CFG_W'(MAX_ROWS), CFG_W'(MAX_COLS));
            end else begin
                write_grid(pick_dim(MAX_ROWS), pick_dim(MAX_COLS));
            end
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 15;
                default: gap_pct = 40;
            endcase
            phase++;
            send_item(CMD_BEGIN, pick_rnd(), 1'b0, '0);
            rand_items++;
            while (trail_depth != 0 && rand_items < RAND_ITEMS) begin
                if (rand_items >= RAND_ITEMS - QUIET_ITEMS && !quiet_tail) begin
                    quiet_tail <= 1'b1;
                end
                roll = $urandom_range(0, 199);
                if (roll < 2) begin
                    drain();
                    write_grid(CFG_W'($urandom_range(0, 31)), CFG_W'($urandom_range(0, 31)));
                end else if (roll < 10) begin
                    send_item(logic'($urandom_range(0, 1)), pick_rnd(), 1'b0, '0);
                    rand_items++;
                end else begin
                    send_item(CMD_STEP, pick_rnd(), 1'b0, '0);
                    rand_items++;
                end
            end
            repeat ($urandom_range(0, 2)) begin
                send_item(CMD_STEP, pick_rnd(), 1'b0, '0);
                rand_items++;
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_moves.size() == 0) begin
            $display("dfs_maze_carver_tb: PASS");
        end else begin
            $display("dfs_maze_carver_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/dmc_pkg.sv
rtl/core/dmc_ram.sv
rtl/core/dmc_ctrl.sv
rtl/core/dmc_dp.sv
rtl/core/dfs_maze_carver.sv
test/dfs_maze_carver_tb.sv
